### rtl/sas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sas_pkg;

  // Default build values
  localparam int unsigned MaxSignalsDef    = 16;
  localparam int unsigned MaxMarkersDef    = 8;
  localparam int unsigned DefaultPeriodDef = 83333;

  // Field widths
  localparam int unsigned OpW     = 3;
  localparam int unsigned DtW     = 24;
  localparam int unsigned MIdxW   = 3;
  localparam int unsigned FrameW  = 16;
  localparam int unsigned IdW     = 16;
  localparam int unsigned KindW   = 3;
  localparam int unsigned ShownW  = 17;
  localparam int unsigned LoopW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 24;
  localparam int unsigned SpeedW  = 16;
  localparam int unsigned ElapW   = 32;
  localparam int unsigned ProdW   = DtW + SpeedW;
  localparam int unsigned DivW    = ProdW + 1;

  typedef enum logic [OpW-1:0] {
    OP_ADVANCE = 3'd0,
    OP_PLAY    = 3'd1,
    OP_PAUSE   = 3'd2,
    OP_RESUME  = 3'd3,
    OP_STOP    = 3'd4,
    OP_MARKER  = 3'd5
  } op_e;

  typedef enum logic [KindW-1:0] {
    KIND_STARTED  = 3'd0,
    KIND_EVENT    = 3'd1,
    KIND_LOOPED   = 3'd2,
    KIND_FINISHED = 3'd3,
    KIND_REPORT   = 3'd4
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_COUNT  = 3'd0,
    CFG_FRAME_PERIOD = 3'd1,
    CFG_SPEED        = 3'd2,
    CFG_PING_PONG    = 3'd3,
    CFG_LOOPING      = 3'd4,
    CFG_FIRST_FRAME  = 3'd5,
    CFG_MARKER_COUNT = 3'd6,
    CFG_SIGNAL_CAP   = 3'd7
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_START,
    ST_SCAN,
    ST_CHECK,
    ST_LOAD,
    ST_DIV,
    ST_DIVEND,
    ST_WALK,
    ST_REPORT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic  ld_in;
    logic  apply_op;
    logic  clr_start;
    logic  scan_clr;
    logic  scan_next;
    logic  mul_go;
    logic  div_init;
    logic  div_step;
    logic  div_done;
    logic  step_go;
    logic  emit_en;
    kind_e emit_kind;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OpW-1:0] opcode;
    logic           active;
    logic           start_pending;
    logic           adv_idle;
    logic           scan_done;
    logic           scan_match;
    logic           div_last;
    logic           steps_done;
    logic           step_fin;
    logic           step_loop;
    logic           slot_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

### rtl/sas_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Command channel
interface sas_cmd_if;
  import sas_pkg::*;
  logic               valid;
  logic               ready;
  logic [OpW-1:0]     opcode;
  logic [DtW-1:0]     delta_time;
  logic [MIdxW-1:0]   marker_index;
  logic [FrameW-1:0]  marker_frame;
  logic [IdW-1:0]     marker_id;

  modport source (output valid, opcode, delta_time, marker_index, marker_frame, marker_id,
                  input ready);
  modport sink   (input valid, opcode, delta_time, marker_index, marker_frame, marker_id,
                  output ready);
endinterface

// Signal channel
interface sas_sig_if;
  import sas_pkg::*;
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  signal_kind;
  logic [FrameW-1:0] signal_frame;
  logic [IdW-1:0]    signal_id;
  logic [ShownW-1:0] shown_frame;
  logic [LoopW-1:0]  loop_count;
  logic              is_playing;
  logic              is_finished;
  logic              last;

  modport source (output valid, signal_kind, signal_frame, signal_id, shown_frame, loop_count,
                  is_playing, is_finished, last, input ready);
  modport sink   (input valid, signal_kind, signal_frame, signal_id, shown_frame, loop_count,
                  is_playing, is_finished, last, output ready);
endinterface

`default_nettype wire

### rtl/sas_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module sas_datapath #(
  parameter int unsigned MaxSignals    = sas_pkg::MaxSignalsDef,
  parameter int unsigned MaxMarkers    = sas_pkg::MaxMarkersDef,
  parameter int unsigned DefaultPeriod = sas_pkg::DefaultPeriodDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sas_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [sas_pkg::CfgW-1:0]      cfg_data_i,
  input  wire logic [sas_pkg::OpW-1:0]       opcode_i,
  input  wire logic [sas_pkg::DtW-1:0]       delta_time_i,
  input  wire logic [sas_pkg::MIdxW-1:0]     marker_index_i,
  input  wire logic [sas_pkg::FrameW-1:0]    marker_frame_i,
  input  wire logic [sas_pkg::IdW-1:0]       marker_id_i,
  input  wire sas_pkg::ctrl_cmd_t            cmd_i,
  output sas_pkg::ctrl_sts_t                 sts_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [sas_pkg::KindW-1:0]          signal_kind_o,
  output logic [sas_pkg::FrameW-1:0]         signal_frame_o,
  output logic [sas_pkg::IdW-1:0]            signal_id_o,
  output logic [sas_pkg::ShownW-1:0]         shown_frame_o,
  output logic [sas_pkg::LoopW-1:0]          loop_count_o,
  output logic                               is_playing_o,
  output logic                               is_finished_o,
  output logic                               last_o
);
  import sas_pkg::*;

  localparam int unsigned SCW = $clog2(MaxSignals + 1);
  localparam int unsigned MCW = $clog2(MaxMarkers + 1);
  localparam int unsigned MIW = (MaxMarkers > 1) ? $clog2(MaxMarkers) : 1;

  // Configuration registers
  logic [FrameW-1:0] fc_q, ff_q;
  logic [CfgW-1:0]   period_q;
  logic [SpeedW-1:0] speed_q;
  logic              pp_q, loop_en_q;
  logic [7:0]        mc_q;
  logic [4:0]        cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q      <= '0;
      period_q  <= '0;
      speed_q   <= 16'd256;
      pp_q      <= 1'b0;
      loop_en_q <= 1'b0;
      ff_q      <= '0;
      mc_q      <= '0;
      cap_q     <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_FRAME_COUNT:  fc_q      <= cfg_data_i[FrameW-1:0];
        CFG_FRAME_PERIOD: period_q  <= cfg_data_i;
        CFG_SPEED:        speed_q   <= cfg_data_i[SpeedW-1:0];
        CFG_PING_PONG:    pp_q      <= cfg_data_i[0];
        CFG_LOOPING:      loop_en_q <= cfg_data_i[0];
        CFG_FIRST_FRAME:  ff_q      <= cfg_data_i[FrameW-1:0];
        CFG_MARKER_COUNT: mc_q      <= cfg_data_i[7:0];
        CFG_SIGNAL_CAP:   cap_q     <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Latched command item
  logic [OpW-1:0]    op_q;
  logic [DtW-1:0]    dt_q;
  logic [MIdxW-1:0]  midx_q;
  logic [FrameW-1:0] mfr_q;
  logic [IdW-1:0]    mid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      op_q   <= opcode_i;
      dt_q   <= delta_time_i;
      midx_q <= marker_index_i;
      mfr_q  <= marker_frame_i;
      mid_q  <= marker_id_i;
    end
  end

  // Marker table, frame in the low half and id in the high half
  logic [31:0] mtab_q [MaxMarkers];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxMarkers; i++) mtab_q[i] <= '0;
    end else if (cmd_i.apply_op && op_e'(op_q) == OP_MARKER) begin
      for (int i = 0; i < MaxMarkers; i++) begin
        if ({29'd0, midx_q} == 32'(i)) mtab_q[i] <= {mid_q, mfr_q};
      end
    end
  end

  // Animator state
  logic [FrameW-1:0] pos_q;
  logic              rev_q, playing_q, done_q, startp_q, active_q;
  logic [LoopW-1:0]  loops_q;
  logic [ElapW-1:0]  elapsed_q;

  // Step logic
  logic [FrameW:0]   pos_inc;
  logic              at_end;
  logic [FrameW-1:0] pos_n;
  logic              rev_n, loop_inc, step_fin, step_loop;

  always_comb begin
    pos_inc   = {1'b0, pos_q} + 17'd1;
    at_end    = pos_inc >= {1'b0, fc_q};
    pos_n     = pos_q;
    rev_n     = rev_q;
    loop_inc  = 1'b0;
    step_fin  = 1'b0;
    step_loop = 1'b0;
    if (pp_q) begin
      if (rev_q) begin
        if (pos_q == '0) begin
          rev_n     = 1'b0;
          loop_inc  = 1'b1;
          step_fin  = !loop_en_q;
          step_loop = loop_en_q;
        end else begin
          pos_n = pos_q - 16'd1;
        end
      end else if (at_end) begin
        rev_n = 1'b1;
        if (pos_q != '0) pos_n = pos_q - 16'd1;
      end else begin
        pos_n = pos_inc[FrameW-1:0];
      end
    end else if (at_end) begin
      if (!loop_en_q) begin
        step_fin = 1'b1;
      end else begin
        pos_n     = '0;
        loop_inc  = 1'b1;
        step_loop = 1'b1;
      end
    end else begin
      pos_n = pos_inc[FrameW-1:0];
    end
  end

  // Multiply, divide and step counting
  logic [ProdW-1:0]  prod_q;
  logic [DivW-1:0]   dvd_q, quo_q;
  logic [ElapW-1:0]  rem_q;
  logic [5:0]        dcnt_q;
  logic [SCW-1:0]    pend_q, stepc_q;
  logic [ElapW-1:0]  unit_w;
  logic [ElapW+1:0]  trial;
  logic [DivW-1:0]   sum_w;
  logic [SCW-1:0]    capped;

  assign unit_w = {(period_q != '0) ? period_q : CfgW'(DefaultPeriod), 8'h00};
  assign trial  = {1'b0, rem_q, dvd_q[DivW-1]} - {2'b00, unit_w};
  assign sum_w  = DivW'(elapsed_q) + DivW'(prod_q);
  assign capped = (quo_q > DivW'(MaxSignals)) ? SCW'(MaxSignals) : quo_q[SCW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go) prod_q <= ProdW'(dt_q) * ProdW'(speed_q);
    if (cmd_i.div_init) begin
      dvd_q  <= sum_w;
      rem_q  <= '0;
      quo_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q  <= {dvd_q[DivW-2:0], 1'b0};
      dcnt_q <= dcnt_q + 6'd1;
      if (!trial[ElapW+1]) begin
        rem_q <= trial[ElapW-1:0];
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[ElapW-2:0], dvd_q[DivW-1]};
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
  end

  // Animator state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      rev_q     <= 1'b0;
      playing_q <= 1'b0;
      done_q    <= 1'b0;
      startp_q  <= 1'b0;
      active_q  <= 1'b0;
      loops_q   <= '0;
      elapsed_q <= '0;
      pend_q    <= '0;
      stepc_q   <= '0;
    end else begin
      if (cmd_i.apply_op) begin
        case (op_e'(op_q))
          OP_PLAY, OP_STOP: begin
            pos_q     <= '0;
            rev_q     <= 1'b0;
            done_q    <= 1'b0;
            loops_q   <= '0;
            elapsed_q <= '0;
            playing_q <= op_e'(op_q) == OP_PLAY;
            startp_q  <= op_e'(op_q) == OP_PLAY;
            active_q  <= op_e'(op_q) == OP_PLAY;
          end
          OP_PAUSE:  playing_q <= 1'b0;
          OP_RESUME: if (active_q && !done_q) playing_q <= 1'b1;
          default: ;
        endcase
      end
      if (cmd_i.clr_start) startp_q <= 1'b0;
      if (cmd_i.div_done) begin
        elapsed_q <= rem_q;
        pend_q    <= capped;
        stepc_q   <= '0;
      end
      if (cmd_i.step_go) begin
        stepc_q <= stepc_q + SCW'(1);
        pos_q   <= pos_n;
        rev_q   <= rev_n;
        if (loop_inc) loops_q <= loops_q + 32'd1;
        if (step_fin) begin
          playing_q <= 1'b0;
          done_q    <= 1'b1;
        end
      end
    end
  end

  // Marker scan
  logic [MCW-1:0] sidx_q;
  logic [7:0]     n_w;
  logic [31:0]    entry;

  assign n_w   = (mc_q < 8'(MaxMarkers)) ? mc_q : 8'(MaxMarkers);
  assign entry = mtab_q[sidx_q[MIW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sidx_q <= '0;
    end else if (cmd_i.scan_clr) begin
      sidx_q <= '0;
    end else if (cmd_i.scan_next) begin
      sidx_q <= sidx_q + MCW'(1);
    end
  end

  // Output slot and per-command signal count
  logic [SCW-1:0] ocnt_q;
  logic [7:0]     lim8;
  logic           room, load, is_rep;

  assign lim8   = (8'(cap_q) < 8'(MaxSignals)) ? 8'(cap_q) : 8'(MaxSignals);
  assign room   = 8'(ocnt_q) < lim8;
  assign is_rep = cmd_i.emit_kind == KIND_REPORT;
  assign load   = cmd_i.emit_en && (is_rep || room);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.ld_in) ocnt_q <= '0;
      else if (load && !is_rep) ocnt_q <= ocnt_q + SCW'(1);
      if (load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      signal_kind_o  <= cmd_i.emit_kind;
      signal_id_o    <= (cmd_i.emit_kind == KIND_EVENT) ? entry[31:16] : '0;
      shown_frame_o  <= '0;
      loop_count_o   <= '0;
      is_playing_o   <= 1'b0;
      is_finished_o  <= 1'b0;
      last_o         <= 1'b0;
      case (cmd_i.emit_kind)
        KIND_STARTED, KIND_LOOPED: signal_frame_o <= '0;
        default:                   signal_frame_o <= pos_q;
      endcase
      if (is_rep) begin
        shown_frame_o <= active_q ? (ShownW'(ff_q) + ShownW'(pos_q)) : '0;
        loop_count_o  <= loops_q;
        is_playing_o  <= playing_q;
        is_finished_o <= done_q;
        last_o        <= 1'b1;
      end
    end
  end

  // Status
  always_comb begin
    sts_o.opcode        = op_q;
    sts_o.active        = active_q;
    sts_o.start_pending = startp_q;
    sts_o.adv_idle      = !playing_q || done_q || fc_q == '0;
    sts_o.scan_done     = 8'(sidx_q) >= n_w;
    sts_o.scan_match    = entry[15:0] == pos_q;
    sts_o.div_last      = dcnt_q == 6'(DivW - 1);
    sts_o.steps_done    = stepc_q == pend_q;
    sts_o.step_fin      = step_fin;
    sts_o.step_loop     = step_loop;
    sts_o.slot_free     = !out_valid_o || out_ready_i;
  end

endmodule

`default_nettype wire

### rtl/sas_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sas_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire sas_pkg::ctrl_sts_t sts_i,
  output sas_pkg::ctrl_cmd_t      cmd_o
);
  import sas_pkg::*;

  state_e state_q, state_d;
  logic   from_start_q, from_start_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      from_start_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      from_start_q <= from_start_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    from_start_d = from_start_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.emit_kind = KIND_REPORT;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (op_e'(sts_i.opcode) == OP_ADVANCE) begin
          if (!sts_i.active) state_d = ST_REPORT;
          else if (sts_i.start_pending) state_d = ST_START;
          else state_d = ST_CHECK;
        end else begin
          cmd_o.apply_op = 1'b1;
          state_d        = ST_REPORT;
        end
      end
      ST_START: begin
        if (sts_i.slot_free) begin
          cmd_o.clr_start = 1'b1;
          cmd_o.emit_en   = 1'b1;
          cmd_o.emit_kind = KIND_STARTED;
          cmd_o.scan_clr  = 1'b1;
          from_start_d    = 1'b1;
          state_d         = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = from_start_q ? ST_CHECK : ST_WALK;
        end else if (!sts_i.scan_match) begin
          cmd_o.scan_next = 1'b1;
        end else if (sts_i.slot_free) begin
          cmd_o.emit_en   = 1'b1;
          cmd_o.emit_kind = KIND_EVENT;
          cmd_o.scan_next = 1'b1;
        end
      end
      ST_CHECK: begin
        if (sts_i.adv_idle) begin
          state_d = ST_REPORT;
        end else begin
          cmd_o.mul_go = 1'b1;
          state_d      = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_DIVEND;
      end
      ST_DIVEND: begin
        cmd_o.div_done = 1'b1;
        state_d        = ST_WALK;
      end
      ST_WALK: begin
        if (sts_i.steps_done) begin
          state_d = ST_REPORT;
        end else if (sts_i.slot_free) begin
          cmd_o.step_go = 1'b1;
          if (sts_i.step_fin) begin
            cmd_o.emit_en   = 1'b1;
            cmd_o.emit_kind = KIND_FINISHED;
            state_d         = ST_REPORT;
          end else begin
            cmd_o.emit_en   = sts_i.step_loop;
            cmd_o.emit_kind = KIND_LOOPED;
            cmd_o.scan_clr  = 1'b1;
            from_start_d    = 1'b0;
            state_d         = ST_SCAN;
          end
        end
      end
      ST_REPORT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_en   = 1'b1;
          cmd_o.emit_kind = KIND_REPORT;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/sprite_animation_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Port        Dir  Carries
// command  cmd_i       in   opcode, delta_time, marker_index/frame/id
// signal   sig_o       out  signal kind/frame/id, report fields, last
// config   cfg_*_i     in   register index and write data
//
// One command at a time. A non-advance command is applied in the decode
// state and then loads its report in the report state. An advance runs the
// multiply, the divider load and the 41-step restoring divider before any
// frame step; the marker scan after the start and after each step that does
// not finish checks one entry at a time. Reset is asynchronous; the marker
// table clears at once. A stalled signal output holds the sequencer
// wherever it next needs to emit.

module sprite_animation_sequencer #(
  parameter int unsigned MaxSignals    = sas_pkg::MaxSignalsDef,
  parameter int unsigned MaxMarkers    = sas_pkg::MaxMarkersDef,
  parameter int unsigned DefaultPeriod = sas_pkg::DefaultPeriodDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [sas_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [sas_pkg::CfgW-1:0]    cfg_data_i,
  sas_cmd_if.sink                          cmd_i,
  sas_sig_if.source                        sig_o
);
  import sas_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  sas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sas_datapath #(
    .MaxSignals    (MaxSignals),
    .MaxMarkers    (MaxMarkers),
    .DefaultPeriod (DefaultPeriod)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (cmd_i.opcode),
    .delta_time_i   (cmd_i.delta_time),
    .marker_index_i (cmd_i.marker_index),
    .marker_frame_i (cmd_i.marker_frame),
    .marker_id_i    (cmd_i.marker_id),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (sig_o.valid),
    .out_ready_i    (sig_o.ready),
    .signal_kind_o  (sig_o.signal_kind),
    .signal_frame_o (sig_o.signal_frame),
    .signal_id_o    (sig_o.signal_id),
    .shown_frame_o  (sig_o.shown_frame),
    .loop_count_o   (sig_o.loop_count),
    .is_playing_o   (sig_o.is_playing),
    .is_finished_o  (sig_o.is_finished),
    .last_o         (sig_o.last)
  );

endmodule

`default_nettype wire

### sim/sprite_animation_sequencer_test.sv
`timescale 1ns / 1ps

module sprite_animation_sequencer_test;
  import sas_pkg::*;

  // Opcodes outside the defined set
  localparam logic [OpW-1:0] OpSpare6 = 3'd6;
  localparam logic [OpW-1:0] OpSpare7 = 3'd7;
  localparam int unsigned    WatchdogLimit = 20000;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [FrameW-1:0] frame;
    logic [IdW-1:0]    id;
    logic [ShownW-1:0] shown;
    logic [LoopW-1:0]  loops;
    logic              playing;
    logic              finished;
    logic              last;
  } signal_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  sas_cmd_if cmd_bus ();
  sas_sig_if sig_bus ();

  sprite_animation_sequencer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_bus),
    .sig_o      (sig_bus)
  );

  always #5 clk_i = ~clk_i;

  // Shadow registers and animator state
  logic [15:0] sh_frame_count, sh_speed, sh_first_frame;
  logic [23:0] sh_period;
  logic        sh_ping_pong, sh_looping;
  logic [7:0]  sh_marker_count;
  logic [4:0]  sh_capacity;
  logic [15:0] an_position;
  logic        an_reversing, an_playing, an_done, an_start_pending, an_active;
  logic [31:0] an_loops, an_elapsed;
  logic [31:0] an_markers [MaxMarkersDef];

  signal_t expected_signals[$];
  int      sig_kept, sig_limit;
  int      errors = 0;
  int      commands_sent = 0;
  int      signals_seen = 0;
  int      idle_cycles = 0;
  bit      idle_on = 1'b1;
  int      hold_req = 0;

  // Predictor: signal emission with per-command capacity
  task automatic push_signal(input logic [KindW-1:0] kind, input logic [15:0] frame,
                             input logic [15:0] id);
    signal_t s;
    if (sig_kept < sig_limit) begin
      s = '0;
      s.kind = kind;
      s.frame = frame;
      s.id = id;
      expected_signals.push_back(s);
      sig_kept++;
    end
  endtask

  task automatic markers_at(input logic [15:0] frame);
    int n;
    n = (sh_marker_count < MaxMarkersDef) ? sh_marker_count : MaxMarkersDef;
    for (int i = 0; i < n; i++)
      if (an_markers[i][15:0] == frame) push_signal(KIND_EVENT, frame, an_markers[i][31:16]);
  endtask

  task automatic clear_animation();
    an_position = '0; an_reversing = 0; an_playing = 0; an_done = 0;
    an_start_pending = 0; an_active = 0; an_loops = '0; an_elapsed = '0;
  endtask

  task automatic walk_frames(input logic [23:0] dt);
    logic [63:0] unit, sum, steps;
    logic        at_end;
    if (!an_active) return;
    if (an_start_pending) begin
      an_start_pending = 0;
      push_signal(KIND_STARTED, 16'd0, 16'd0);
      markers_at(16'd0);
    end
    if (!an_playing || an_done || sh_frame_count == 0) return;
    unit = 64'(sh_period != 0 ? sh_period : DefaultPeriodDef) * 256;
    sum = 64'(an_elapsed) + 64'(dt) * 64'(sh_speed);
    steps = sum / unit;
    an_elapsed = 32'(sum - steps * unit);
    if (steps > MaxSignalsDef) steps = MaxSignalsDef;
    for (int s = 0; s < steps; s++) begin
      at_end = (32'(an_position) + 1) >= 32'(sh_frame_count);
      if (sh_ping_pong) begin
        if (an_reversing) begin
          if (an_position == 0) begin
            // turnaround at frame zero: counts a loop without moving
            an_reversing = 0;
            an_loops++;
            if (!sh_looping) begin
              an_playing = 0; an_done = 1;
              push_signal(KIND_FINISHED, an_position, 16'd0);
              break;
            end
            push_signal(KIND_LOOPED, 16'd0, 16'd0);
          end else an_position--;
        end else if (at_end) begin
          an_reversing = 1;
          if (an_position > 0) an_position--;
        end else an_position++;
      end else if (at_end) begin
        if (!sh_looping) begin
          an_playing = 0; an_done = 1;
          push_signal(KIND_FINISHED, an_position, 16'd0);
          break;
        end
        an_position = '0;
        an_loops++;
        push_signal(KIND_LOOPED, 16'd0, 16'd0);
      end else an_position++;
      markers_at(an_position);
    end
  endtask

  task automatic predict_command(input logic [2:0] op, input logic [23:0] dt,
                                 input logic [2:0] idx, input logic [15:0] mfr,
                                 input logic [15:0] mid);
    signal_t r;
    sig_kept = 0;
    sig_limit = (sh_capacity < MaxSignalsDef) ? sh_capacity : MaxSignalsDef;
    case (op)
      OP_ADVANCE: walk_frames(dt);
      OP_PLAY: begin
        clear_animation();
        an_playing = 1; an_start_pending = 1; an_active = 1;
      end
      OP_PAUSE:  an_playing = 0;
      OP_RESUME: if (an_active && !an_done) an_playing = 1;
      OP_STOP:   clear_animation();
      OP_MARKER: if (idx < MaxMarkersDef) an_markers[idx] = {mid, mfr};
      default: ;
    endcase
    r = '0;
    r.kind = KIND_REPORT;
    r.frame = an_position;
    r.shown = an_active ? 17'(17'(sh_first_frame) + 17'(an_position)) : '0;
    r.loops = an_loops;
    r.playing = an_playing;
    r.finished = an_done;
    r.last = 1'b1;
    expected_signals.push_back(r);
  endtask

  // Command sender: drives at the falling edge, predicts on acceptance
  task automatic send_cmd(input logic [2:0] op, input logic [23:0] dt = '0,
                          input logic [2:0] idx = '0, input logic [15:0] mfr = '0,
                          input logic [15:0] mid = '0);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_bus.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    cmd_bus.valid = 1'b1;
    cmd_bus.opcode = op;
    cmd_bus.delta_time = dt;
    cmd_bus.marker_index = idx;
    cmd_bus.marker_frame = mfr;
    cmd_bus.marker_id = mid;
    forever begin
      @(posedge clk_i);
      if (cmd_bus.ready) break;
    end
    predict_command(op, dt, idx, mfr, mid);
    commands_sent++;
    @(negedge clk_i);
  endtask

  // Wait until every expected item has come, then let the block settle
  task automatic drain();
    if (cmd_bus.valid) cmd_bus.valid = 1'b0;
    while (expected_signals.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_e idx, input logic [23:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_FRAME_COUNT:  sh_frame_count = data[15:0];
      CFG_FRAME_PERIOD: sh_period = data;
      CFG_SPEED:        sh_speed = data[15:0];
      CFG_PING_PONG:    sh_ping_pong = data[0];
      CFG_LOOPING:      sh_looping = data[0];
      CFG_FIRST_FRAME:  sh_first_frame = data[15:0];
      CFG_MARKER_COUNT: sh_marker_count = data[7:0];
      CFG_SIGNAL_CAP:   sh_capacity = data[4:0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(input logic [15:0] fc, input logic [23:0] per, input logic [15:0] spd,
                         input logic pp, input logic lp, input logic [15:0] ff,
                         input logic [7:0] mc, input logic [4:0] cap);
    cfg_write(CFG_FRAME_COUNT, 24'(fc));
    cfg_write(CFG_FRAME_PERIOD, per);
    cfg_write(CFG_SPEED, 24'(spd));
    cfg_write(CFG_PING_PONG, 24'(pp));
    cfg_write(CFG_LOOPING, 24'(lp));
    cfg_write(CFG_FIRST_FRAME, 24'(ff));
    cfg_write(CFG_MARKER_COUNT, 24'(mc));
    cfg_write(CFG_SIGNAL_CAP, 24'(cap));
  endtask

  // Receiver: random stalls, plus a long hold on request
  initial begin
    sig_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        sig_bus.ready = 1'b0;
        repeat (hold_req - 1) @(negedge clk_i);
        hold_req = 0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        sig_bus.ready = 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk_i);
      end else sig_bus.ready = 1'b1;
    end
  end

  // Result checker and watchdog
  always @(posedge clk_i) begin
    signal_t got, want;
    got = {sig_bus.signal_kind, sig_bus.signal_frame, sig_bus.signal_id, sig_bus.shown_frame,
           sig_bus.loop_count, sig_bus.is_playing, sig_bus.is_finished, sig_bus.last};
    if ((cmd_bus.valid && cmd_bus.ready) || (sig_bus.valid && sig_bus.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (rst_ni && sig_bus.valid && sig_bus.ready) begin
      signals_seen++;
      if (expected_signals.size() == 0) begin
        $display("%0t: unexpected item, actual %p", $time, got);
        errors++;
      end else begin
        want = expected_signals.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
          errors++;
        end
      end
    end
    if (idle_cycles > WatchdogLimit) begin
      $display("%0t: watchdog expired with %0d items outstanding", $time,
               expected_signals.size());
      $display("sprite_animation_sequencer_test: FAIL");
      $finish;
    end
  end

  // Directed: commands, markers, pause and resume, spare opcodes
  task automatic test_commands();
    cfg_all(16'd4, 24'd10, 16'd256, 1'b0, 1'b1, 16'd100, 8'd3, 5'd16);
    send_cmd(OP_MARKER, '0, 3'd0, 16'd0, 16'hFFFF);
    send_cmd(OP_MARKER, '0, 3'd1, 16'd2, 16'd1);
    send_cmd(OP_MARKER, '0, 3'd7, 16'hFFFF, 16'h8000);
    send_cmd(OP_ADVANCE, 24'd50);          // inactive: report only
    send_cmd(OP_PLAY);
    send_cmd(OP_PAUSE);
    send_cmd(OP_ADVANCE, 24'd0);           // start fires even while paused
    send_cmd(OP_ADVANCE, 24'd30);
    send_cmd(OP_RESUME);
    send_cmd(OP_ADVANCE, 24'd25);
    send_cmd(OP_ADVANCE, 24'hFFFFFF);      // step count capped
    send_cmd(OpSpare6);
    send_cmd(OpSpare7);
    send_cmd(OP_STOP);
    send_cmd(OP_RESUME);                   // inactive: stays stopped
    send_cmd(OP_ADVANCE, 24'd40);
    drain();
  endtask

  // Directed: ping-pong turnaround, finish, capacity limits
  task automatic test_ping_pong();
    cfg_all(16'd3, 24'd1, 16'd256, 1'b1, 1'b0, 16'hFFFF, 8'd8, 5'd2);
    send_cmd(OP_PLAY);
    send_cmd(OP_ADVANCE, 24'd3);
    send_cmd(OP_ADVANCE, 24'd10);
    send_cmd(OP_RESUME);                   // done: no effect
    drain();
    cfg_write(CFG_SIGNAL_CAP, 24'd0);
    cfg_write(CFG_LOOPING, 24'd1);
    send_cmd(OP_PLAY);
    send_cmd(OP_ADVANCE, 24'd12);
    drain();
    cfg_write(CFG_SIGNAL_CAP, 24'd31);
    cfg_write(CFG_FRAME_COUNT, 24'd1);
    send_cmd(OP_ADVANCE, 24'd9);
    drain();
  endtask

  // Directed: register extremes and position beyond the frame count
  task automatic test_extremes();
    cfg_all(16'hFFFF, 24'hFFFFFF, 16'hFFFF, 1'b0, 1'b0, 16'hFFFF, 8'hFF, 5'd16);
    send_cmd(OP_PLAY);
    send_cmd(OP_ADVANCE, 24'hFFFFFF);
    drain();
    cfg_write(CFG_FRAME_PERIOD, 24'd0);
    cfg_write(CFG_SPEED, 24'd0);
    send_cmd(OP_ADVANCE, 24'hFFFFFF);
    drain();
    cfg_write(CFG_FRAME_COUNT, 24'd0);
    cfg_write(CFG_SPEED, 24'd256);
    send_cmd(OP_ADVANCE, 24'hFFFFFF);
    drain();
    cfg_all(16'd8, 24'd2, 16'd512, 1'b0, 1'b0, 16'd0, 8'd0, 5'd16);
    send_cmd(OP_PLAY);
    send_cmd(OP_ADVANCE, 24'd6);
    drain();
    cfg_write(CFG_FRAME_COUNT, 24'd2);     // position now past the end
    send_cmd(OP_ADVANCE, 24'd1);
    drain();
  endtask

  task automatic random_command(input logic [23:0] per_eff);
    logic [63:0] dt;
    int          pick;
    pick = $urandom_range(0, 99);
    dt = ($urandom_range(0, 64) * 64'(per_eff) * 256) / ((sh_speed == 0) ? 1 : sh_speed);
    dt = dt / 3;
    if ($urandom_range(0, 9) == 0) dt = $urandom & 24'hFFFFFF;
    if (dt > 24'hFFFFFF) dt = 24'hFFFFFF;
    if (pick < 70) send_cmd(OP_ADVANCE, dt[23:0]);
    else if (pick < 75) send_cmd(OP_PLAY);
    else if (pick < 80) send_cmd(OP_PAUSE);
    else if (pick < 86) send_cmd(OP_RESUME);
    else if (pick < 89) send_cmd(OP_STOP);
    else if (pick < 97)
      send_cmd(OP_MARKER, 24'($urandom), 3'($urandom),
               ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7)),
               16'($urandom));
    else send_cmd(($urandom_range(0, 1) != 0) ? OpSpare6 : OpSpare7, 24'($urandom));
  endtask

  // Random phases: random settings, play, then mostly advances
  task automatic test_random(input int phases, input int per_phase);
    logic [15:0] fc, spd;
    logic [23:0] per, per_eff;
    for (int p = 0; p < phases; p++) begin
      fc = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
      per = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(1, 300));
      if ($urandom_range(0, 9) == 0) per = '0;
      spd = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd256;
      cfg_all(fc, per, spd, 1'($urandom), 1'($urandom), 16'($urandom),
              ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8)),
              ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'd16);
      per_eff = (per != 0) ? per : 24'(DefaultPeriodDef);
      for (int m = 0; m < MaxMarkersDef; m++)
        send_cmd(OP_MARKER, '0, 3'(m), 16'($urandom_range(0, 7)), 16'($urandom));
      send_cmd(OP_PLAY);
      for (int i = 0; i < per_phase; i++) random_command(per_eff);
      drain();
    end
  endtask

  // Long receiver hold while commands keep coming
  task automatic test_backpressure();
    cfg_all(16'd5, 24'd4, 16'd256, 1'b1, 1'b1, 16'd7, 8'd8, 5'd16);
    for (int m = 0; m < MaxMarkersDef; m++)
      send_cmd(OP_MARKER, '0, 3'(m), 16'(m % 5), 16'(m + 1));
    send_cmd(OP_PLAY);
    hold_req = 400;
    for (int i = 0; i < 10; i++) send_cmd(OP_ADVANCE, 24'(4 * $urandom_range(4, 16)));
    drain();
  endtask

  initial begin
    cmd_bus.valid = 1'b0;
    cmd_bus.opcode = OP_ADVANCE;
    cmd_bus.delta_time = '0;
    cmd_bus.marker_index = '0;
    cmd_bus.marker_frame = '0;
    cmd_bus.marker_id = '0;
    sh_frame_count = '0; sh_period = '0; sh_speed = 16'd256; sh_ping_pong = 0;
    sh_looping = 0; sh_first_frame = '0; sh_marker_count = '0; sh_capacity = 5'd16;
    clear_animation();
    for (int i = 0; i < MaxMarkersDef; i++) an_markers[i] = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_commands();
    test_ping_pong();
    test_extremes();
    test_backpressure();
    test_random(5, 30);
    idle_on = 1'b0;
    test_random(1, 30);

    drain();
    repeat (100) @(negedge clk_i);
    $display("Sent %0d commands, checked %0d items: directed commands, ping-pong,",
             commands_sent, signals_seen);
    $display("register extremes, long output hold and random playback phases.");
    if (errors == 0 && expected_signals.size() == 0) begin
      $display("sprite_animation_sequencer_test: PASS");
    end else begin
      $display("%0d errors, %0d items outstanding", errors, expected_signals.size());
      $display("sprite_animation_sequencer_test: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sas_pkg.sv
rtl/sas_if.sv
rtl/sas_datapath.sv
rtl/sas_ctrl.sv
rtl/sprite_animation_sequencer.sv
sim/sprite_animation_sequencer_test.sv
